// ===== hw/rtl/polynomial_value_and_derivatives_assert.svh =====
// assertion helpers used by the top-level rtl file
`ifndef POLYNOMIAL_VALUE_AND_DERIVATIVES_ASSERT_SVH
`define POLYNOMIAL_VALUE_AND_DERIVATIVES_ASSERT_SVH

// same-cycle implication, checked at every rising edge outside reset
`define PVD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define PVD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pvd_pkg.sv =====
package pvd_pkg;

  // data and coefficient formats
  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  // largest scaled coefficient is 20 * c, which needs 37 signed bits
  localparam int COEFF_W   = 37;
  localparam int ORDER_W   = 3;
  localparam int CFG_IDX_W = 3;

  // one horner chain each for value, slope and curvature
  localparam int NCHAIN   = 3;
  localparam int CH_VALUE = 0;
  localparam int CH_SLOPE = 1;
  localparam int CH_CURV  = 2;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORDER  = 3'd0,
    REG_COEFF0 = 3'd1,
    REG_COEFF1 = 3'd2,
    REG_COEFF2 = 3'd3,
    REG_COEFF3 = 3'd4,
    REG_COEFF4 = 3'd5,
    REG_COEFF5 = 3'd6
  } cfg_reg_e;

  // exact accumulator width after a number of horner steps
  // three guard bits cover the sum of up to six terms
  function automatic int acc_width(input int steps);
    return COEFF_W + 3 + DATA_W * steps;
  endfunction

  // coefficient times a small derivative factor
  function automatic logic signed [COEFF_W-1:0] coeff_scale(input logic [DATA_W-1:0] c,
                                                            input int m);
    logic signed [COEFF_W-1:0] cx;
    cx = COEFF_W'(signed'(c));
    return cx * COEFF_W'(m);
  endfunction

endpackage

// ===== hw/rtl/pvd_step.sv =====
// one horner step: acc * x + coeff << SHIFT, exact
// stage one registers the limb products, stage two sums them
module pvd_step #(
  parameter int IN_W  = 40,
  parameter int OUT_W = 72,
  parameter int SHIFT = 16
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [IN_W-1:0]              acc_i,
  input  logic signed [pvd_pkg::DATA_W-1:0]   x_i,
  input  logic signed [pvd_pkg::COEFF_W-1:0]  coeff_i,
  output logic signed [OUT_W-1:0]             acc_o
);
  import pvd_pkg::*;

  localparam int Limbs = (IN_W + DATA_W - 1) / DATA_W;
  localparam int ExtW  = Limbs * DATA_W;
  localparam int ProdW = 2 * DATA_W + 1;

  logic signed [ExtW-1:0]   acc_ext;
  logic signed [DATA_W:0]   limb   [Limbs];
  logic signed [ProdW-1:0]  prod_d [Limbs];
  logic signed [ProdW-1:0]  prod_q [Limbs];
  logic signed [OUT_W-1:0]  acc_d;
  logic signed [OUT_W-1:0]  acc_q;

  assign acc_ext = ExtW'(acc_i);

  // split into 32-bit limbs, only the top limb carries the sign
  for (genvar j = 0; j < Limbs; j++) begin : g_limb
    if (j == Limbs - 1) begin : g_top
      assign limb[j] = {acc_ext[ExtW-1], acc_ext[j*DATA_W +: DATA_W]};
    end else begin : g_low
      assign limb[j] = {1'b0, acc_ext[j*DATA_W +: DATA_W]};
    end
    assign prod_d[j] = limb[j] * x_i;
  end

  // product stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // sum of shifted limb products plus the next coefficient
  always_comb begin
    acc_d = OUT_W'(coeff_i) <<< SHIFT;
    for (int j = 0; j < Limbs; j++) begin
      acc_d = acc_d + (OUT_W'(prod_q[j]) <<< (DATA_W * j));
    end
  end

  // sum stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== hw/rtl/pvd_round.sv =====
// round half up to q16.16, then clip to the signed 32-bit range
module pvd_round #(
  parameter int IN_W  = 72,
  parameter int SHIFT = 16
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [IN_W-1:0]             acc_i,
  output logic signed [pvd_pkg::DATA_W-1:0]  res_o,
  output logic                               clip_o
);
  import pvd_pkg::*;

  localparam int RndW = IN_W - SHIFT;

  logic signed [IN_W-1:0]      sum;
  logic signed [RndW-1:0]      rnd_q;
  logic [RndW-DATA_W:0]        top_bits;

  // add one half lsb of the result, then drop the fraction
  assign sum = acc_i + (IN_W'(1) <<< (SHIFT - 1));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rnd_q <= sum[IN_W-1:SHIFT];
    end
  end

  // fits when all bits from the 32-bit sign up agree
  assign top_bits = rnd_q[RndW-1:DATA_W-1];
  assign clip_o   = !((&top_bits) || !(|top_bits));
  assign res_o    = clip_o ? (rnd_q[RndW-1] ? SAT_MIN : SAT_MAX) : rnd_q[DATA_W-1:0];

endmodule

// ===== hw/rtl/polynomial_value_and_derivatives.sv =====
// Evaluates p(x) = c0 + c1*x + ... + cn*x^n together with p'(x) and p''(x) for each
// point, all in signed Q16.16; n is the programmed order, clamped to NUM_COEFFS-1. Every
// product and sum is exact, and each result is rounded once (half up) and clipped to the
// 32-bit range, with saturated_o set when any of the three was clipped. The block takes
// one point per clock cycle unless the skid register is full or configuration is written;
// a result passes through the input register, the NUM_COEFFS-1 multiply-add steps of two
// stages each, and the rounding and output registers. A skid register at the output
// lets the pipeline keep one extra result while the consumer stalls.
// Configuration writes are always taken (cfg_ready_o stays high) and must only be made
// while no point is in flight; a point is not taken in a cycle that writes configuration.
`include "polynomial_value_and_derivatives_assert.svh"

module polynomial_value_and_derivatives #(
  parameter int NUM_COEFFS = 6
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [pvd_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [pvd_pkg::DATA_W-1:0]            cfg_data_i,
  // input points
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [pvd_pkg::DATA_W-1:0]     point_i,
  // results
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [pvd_pkg::DATA_W-1:0]     value_o,
  output logic signed [pvd_pkg::DATA_W-1:0]     slope_o,
  output logic signed [pvd_pkg::DATA_W-1:0]     curvature_o,
  output logic                                  saturated_o
);
  import pvd_pkg::*;

  localparam int Deg     = NUM_COEFFS - 1;
  localparam int Nst     = 2 * Deg + 2;
  localparam int XSt     = 2 * Deg - 1;
  localparam int AccMaxW = acc_width(Deg);

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] slope;
    logic signed [DATA_W-1:0] curvature;
    logic                     saturated;
  } result_t;

  logic [ORDER_W-1:0]          order_q;
  logic [DATA_W-1:0]           coeff_q [NUM_COEFFS];
  logic [ORDER_W-1:0]          ord_eff;
  logic signed [COEFF_W-1:0]   k_d [NCHAIN][NUM_COEFFS];
  logic signed [COEFF_W-1:0]   k_q [NCHAIN][NUM_COEFFS];

  logic                        en;
  logic                        in_xfer;
  logic [Nst-1:0]              vp_q;
  logic signed [DATA_W-1:0]    xp_q [XSt];

  logic signed [AccMaxW-1:0]   acc_w [NCHAIN][NUM_COEFFS];
  logic signed [DATA_W-1:0]    res   [NCHAIN];
  logic [NCHAIN-1:0]           clip;

  result_t                     new_res;
  result_t                     out_q;
  result_t                     skid_q;
  logic                        out_valid_q;
  logic                        skid_valid_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= '0;
    end else if (cfg_valid_i && cfg_index_i == REG_ORDER) begin
      order_q <= cfg_data_i[ORDER_W-1:0];
    end
  end

  for (genvar j = 0; j < NUM_COEFFS; j++) begin : g_creg
    localparam logic [CFG_IDX_W-1:0] Idx = CFG_IDX_W'(int'(REG_COEFF0) + j);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        coeff_q[j] <= '0;
      end else if (cfg_valid_i && cfg_index_i == Idx) begin
        coeff_q[j] <= cfg_data_i;
      end
    end
  end

  // order codes above the top power act as the top power
  assign ord_eff = (order_q > ORDER_W'(Deg)) ? ORDER_W'(Deg) : order_q;

  // coefficient sets for p, p' and p'', zero above the order
  for (genvar i = 0; i <= Deg; i++) begin : g_coef
    assign k_d[CH_VALUE][i] = (ORDER_W'(i) <= ord_eff) ? coeff_scale(coeff_q[i], 1) : '0;
    if (i + 1 <= Deg) begin : g_d1
      assign k_d[CH_SLOPE][i] = (ORDER_W'(i + 1) <= ord_eff) ?
                                coeff_scale(coeff_q[i + 1], i + 1) : '0;
    end else begin : g_z1
      assign k_d[CH_SLOPE][i] = '0;
    end
    if (i + 2 <= Deg) begin : g_d2
      assign k_d[CH_CURV][i] = (ORDER_W'(i + 2) <= ord_eff) ?
                               coeff_scale(coeff_q[i + 2], (i + 2) * (i + 1)) : '0;
    end else begin : g_z2
      assign k_d[CH_CURV][i] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NCHAIN; c++) begin
        for (int i = 0; i < NUM_COEFFS; i++) begin
          k_q[c][i] <= '0;
        end
      end
    end else begin
      k_q <= k_d;
    end
  end

  // pipeline advance, held while the skid register is full
  assign en         = !skid_valid_q;
  assign in_ready_o = en && !cfg_valid_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= '0;
    end else if (en) begin
      vp_q <= {vp_q[Nst-2:0], in_xfer};
    end
  end

  // the point travels two stages per horner step
  always_ff @(posedge clk_i) begin
    if (en) begin
      xp_q[0] <= point_i;
      for (int s = 1; s < XSt; s++) begin
        xp_q[s] <= xp_q[s-1];
      end
    end
  end

  // three horner chains of equal depth, leading zeros pad the shorter ones
  for (genvar ch = 0; ch < NCHAIN; ch++) begin : g_chain
    assign acc_w[ch][0] = AccMaxW'(k_q[ch][Deg]);

    for (genvar t = 1; t <= Deg; t++) begin : g_step
      localparam int InW  = acc_width(t - 1);
      localparam int OutW = acc_width(t);
      logic signed [OutW-1:0] acc_out;

      pvd_step #(
        .IN_W  (InW),
        .OUT_W (OutW),
        .SHIFT (FRAC_W * t)
      ) u_step (
        .clk_i   (clk_i),
        .en_i    (en),
        .acc_i   (acc_w[ch][t-1][InW-1:0]),
        .x_i     (xp_q[2*(t-1)]),
        .coeff_i (k_q[ch][Deg-t]),
        .acc_o   (acc_out)
      );

      assign acc_w[ch][t] = AccMaxW'(acc_out);
    end

    pvd_round #(
      .IN_W  (AccMaxW),
      .SHIFT (FRAC_W * Deg)
    ) u_round (
      .clk_i  (clk_i),
      .en_i   (en),
      .acc_i  (acc_w[ch][Deg]),
      .res_o  (res[ch]),
      .clip_o (clip[ch])
    );
  end

  assign new_res.value     = res[CH_VALUE];
  assign new_res.slope     = res[CH_SLOPE];
  assign new_res.curvature = res[CH_CURV];
  assign new_res.saturated = |clip;

  // output register and skid register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_ready_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (vp_q[Nst-1]) begin
      if (out_valid_q && !out_ready_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output and skid payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_q <= skid_q;
      end
    end else if (vp_q[Nst-1]) begin
      if (out_valid_q && !out_ready_i) begin
        skid_q <= new_res;
      end else begin
        out_q <= new_res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_q.value;
  assign slope_o     = out_q.slope;
  assign curvature_o = out_q.curvature;
  assign saturated_o = out_q.saturated;

  // skid entry only exists behind a held output
  `PVD_ASSERT_NOW(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q, "skid full with empty output")
  // no new point while a result waits in the skid register
  `PVD_ASSERT_NOW(a_skid_blocks_in, clk_i, rst_ni, skid_valid_q, !in_ready_o, "input taken with skid full")
  // a finished result meeting a stalled output lands in the skid register
  `PVD_ASSERT_NEXT(a_result_kept, clk_i, rst_ni, vp_q[Nst-1] && !skid_valid_q && out_valid_q && !out_ready_i, skid_valid_q, "finished result dropped")
  // draining the skid register keeps the output full
  `PVD_ASSERT_NEXT(a_skid_drain, clk_i, rst_ni, skid_valid_q && out_ready_i, out_valid_q && !skid_valid_q, "skid drain lost a result")

endmodule
